// ===== rtl/brar_pkg.sv =====
// Package for the best rational approximation unit.
// Holds the widths, the datapath command codes and the status struct.
// No dependencies.
package brar_pkg;

  localparam int FRAC_W = 32;
  localparam int INT_W  = 16;
  localparam int X_W    = INT_W + FRAC_W;
  localparam int DEN_W  = 16;
  localparam int NUM_W  = 32;
  localparam int Q_W    = FRAC_W + 1;
  localparam int N_W    = NUM_W + 1;
  localparam int ERR_W  = X_W + DEN_W + 1;
  localparam int PROD_W = ERR_W + DEN_W;
  localparam int CNT_W  = $clog2(Q_W + 1);

  localparam logic [DEN_W-1:0] LIM_RESET = {DEN_W{1'b1}};

  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_EDIV,
    CMD_SDIV,
    CMD_STEP,
    CMD_MCHK,
    CMD_DUPD,
    CMD_NUPD,
    CMD_SNB,
    CMD_SDB,
    CMD_ERR1,
    CMD_EMUL1,
    CMD_ESAVE,
    CMD_ERR2,
    CMD_EMUL2,
    CMD_OCMP,
    CMD_OCONV
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic q_zero;
    logic over;
  } status_t;

endpackage

// ===== rtl/brar_div.sv =====
// Restoring divider for the best rational approximation unit.
// Produces one quotient bit per cycle while step is asserted; depends on brar_pkg.
module brar_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       step,
  input  logic [brar_pkg::Q_W-1:0]   dividend,
  input  logic [brar_pkg::Q_W-1:0]   divisor,
  output logic [brar_pkg::Q_W-1:0]   quotient,
  output logic [brar_pkg::Q_W-1:0]   remainder,
  output logic                       done
);

  logic [brar_pkg::Q_W-1:0]   rem_r, rem_nxt;
  logic [brar_pkg::Q_W-1:0]   quo_r, quo_nxt;
  logic [brar_pkg::Q_W-1:0]   den_r, den_nxt;
  logic [brar_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [brar_pkg::Q_W:0]     shifted;
  logic [brar_pkg::Q_W:0]     diff;

  assign shifted = {rem_r, quo_r[brar_pkg::Q_W-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      den_nxt = divisor;
      cnt_nxt = brar_pkg::CNT_W'(brar_pkg::Q_W);
    end else if (step && cnt_r != '0) begin
      if (!diff[brar_pkg::Q_W]) begin
        rem_nxt = diff[brar_pkg::Q_W-1:0];
      end else begin
        rem_nxt = shifted[brar_pkg::Q_W-1:0];
      end
      quo_nxt = {quo_r[brar_pkg::Q_W-2:0], ~diff[brar_pkg::Q_W]};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = (cnt_r == '0);

`ifndef NO_ASSERTIONS
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n) step |-> !done)
    else $error("Divider stepped after it finished.");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n) start |=> !done)
    else $error("Divider reported done right after start.");
`endif

endmodule

// ===== rtl/brar_dp.sv =====
// Datapath of the best rational approximation unit: fraction registers,
// shared multiplier, error comparison and result register.
// Depends on brar_pkg and brar_div.
module brar_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  brar_pkg::cmd_t                cmd,
  input  logic [brar_pkg::X_W-1:0]      x_value,
  input  logic                          cfg_we,
  input  logic [brar_pkg::DEN_W-1:0]    cfg_data,
  output brar_pkg::status_t             status,
  output logic [brar_pkg::NUM_W-1:0]    numerator,
  output logic [brar_pkg::DEN_W-1:0]    denominator
);

  localparam int QPAD = brar_pkg::Q_W - brar_pkg::DEN_W;

  logic [brar_pkg::DEN_W-1:0]  lim_r;
  logic [brar_pkg::DEN_W-1:0]  lim_eff;
  logic [brar_pkg::DEN_W-1:0]  lim_rest;
  logic [brar_pkg::X_W-1:0]    x_r;
  logic [brar_pkg::Q_W-1:0]    p_r, q_r;
  logic [brar_pkg::N_W-1:0]    n0_r, n1_r, nb_r;
  logic [brar_pkg::DEN_W-1:0]  d0_r, d1_r, db_r;
  logic [brar_pkg::ERR_W-1:0]  err_r;
  logic [brar_pkg::PROD_W-1:0] prod_r, e1_r;
  logic [brar_pkg::NUM_W-1:0]  num_r;
  logic [brar_pkg::DEN_W-1:0]  den_r;

  logic [brar_pkg::ERR_W-1:0]  mul_a;
  logic [brar_pkg::DEN_W-1:0]  mul_b;
  logic [brar_pkg::PROD_W-1:0] mul_p;
  logic [brar_pkg::ERR_W-1:0]  diff_a, diff_b, abs_diff;
  logic [brar_pkg::N_W-1:0]    diff_n;

  logic                        div_start;
  logic [brar_pkg::Q_W-1:0]    div_dividend, div_divisor, quo, rem;
  logic                        div_done;
  logic [brar_pkg::DEN_W-1:0]  a16;

  assign lim_eff  = (lim_r == '0) ? brar_pkg::DEN_W'(1) : lim_r;
  assign lim_rest = lim_eff - d1_r;
  assign a16      = quo[brar_pkg::DEN_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd)
      brar_pkg::CMD_MCHK: begin
        mul_a = brar_pkg::ERR_W'(quo);
        mul_b = d0_r;
      end
      brar_pkg::CMD_DUPD, brar_pkg::CMD_SNB: begin
        mul_a = brar_pkg::ERR_W'(n0_r);
        mul_b = a16;
      end
      brar_pkg::CMD_SDB: begin
        mul_a = brar_pkg::ERR_W'(x_r);
        mul_b = d0_r;
      end
      brar_pkg::CMD_EMUL1: begin
        mul_a = err_r;
        mul_b = db_r;
      end
      brar_pkg::CMD_ESAVE: begin
        mul_a = brar_pkg::ERR_W'(x_r);
        mul_b = db_r;
      end
      brar_pkg::CMD_EMUL2: begin
        mul_a = err_r;
        mul_b = d0_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = brar_pkg::PROD_W'(mul_a) * brar_pkg::PROD_W'(mul_b);

  assign diff_n   = (cmd == brar_pkg::CMD_ERR2) ? nb_r : n0_r;
  assign diff_a   = brar_pkg::ERR_W'(prod_r[brar_pkg::X_W+brar_pkg::DEN_W-1:0]);
  assign diff_b   = {diff_n, brar_pkg::FRAC_W'(0)};
  assign abs_diff = (diff_a < diff_b) ? (diff_b - diff_a) : (diff_a - diff_b);

  assign div_start    = (cmd == brar_pkg::CMD_EDIV) || (cmd == brar_pkg::CMD_SDIV);
  assign div_dividend = (cmd == brar_pkg::CMD_SDIV) ? {{QPAD{1'b0}}, lim_rest} : p_r;
  assign div_divisor  = (cmd == brar_pkg::CMD_SDIV) ? {{QPAD{1'b0}}, d0_r} : q_r;

  brar_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .step      (cmd == brar_pkg::CMD_STEP),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (quo),
    .remainder (rem),
    .done      (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= brar_pkg::LIM_RESET;
    end else if (cfg_we) begin
      lim_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      brar_pkg::CMD_LOAD: begin
        x_r  <= x_value;
        n0_r <= brar_pkg::N_W'(x_value[brar_pkg::X_W-1:brar_pkg::FRAC_W]);
        n1_r <= brar_pkg::N_W'(1);
        d0_r <= brar_pkg::DEN_W'(1);
        d1_r <= '0;
        p_r  <= {1'b1, brar_pkg::FRAC_W'(0)};
        q_r  <= {1'b0, x_value[brar_pkg::FRAC_W-1:0]};
      end
      brar_pkg::CMD_MCHK: begin
        prod_r <= mul_p;
      end
      brar_pkg::CMD_DUPD: begin
        d1_r   <= d0_r;
        d0_r   <= prod_r[brar_pkg::DEN_W-1:0] + d1_r;
        prod_r <= mul_p;
      end
      brar_pkg::CMD_NUPD: begin
        n1_r <= n0_r;
        n0_r <= prod_r[brar_pkg::N_W-1:0] + n1_r;
        p_r  <= q_r;
        q_r  <= rem;
      end
      brar_pkg::CMD_SNB: begin
        db_r   <= prod_r[brar_pkg::DEN_W-1:0] + d1_r;
        prod_r <= mul_p;
      end
      brar_pkg::CMD_SDB: begin
        nb_r   <= prod_r[brar_pkg::N_W-1:0] + n1_r;
        prod_r <= mul_p;
      end
      brar_pkg::CMD_ERR1, brar_pkg::CMD_ERR2: begin
        err_r <= abs_diff;
      end
      brar_pkg::CMD_EMUL1, brar_pkg::CMD_EMUL2: begin
        prod_r <= mul_p;
      end
      brar_pkg::CMD_ESAVE: begin
        e1_r   <= prod_r;
        prod_r <= mul_p;
      end
      brar_pkg::CMD_OCMP: begin
        if (prod_r < e1_r) begin
          num_r <= nb_r[brar_pkg::NUM_W-1:0];
          den_r <= db_r;
        end else begin
          num_r <= n0_r[brar_pkg::NUM_W-1:0];
          den_r <= d0_r;
        end
      end
      brar_pkg::CMD_OCONV: begin
        num_r <= n0_r[brar_pkg::NUM_W-1:0];
        den_r <= d0_r;
      end
      default: begin
      end
    endcase
  end

  assign status.div_done = div_done;
  assign status.q_zero   = (q_r == '0);
  assign status.over     = (prod_r > brar_pkg::PROD_W'(lim_rest));
  assign numerator       = num_r;
  assign denominator     = den_r;

`ifndef NO_ASSERTIONS
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == brar_pkg::CMD_EDIV) |-> (q_r != '0))
    else $error("Euclid division started with a zero divisor.");
  a_den_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == brar_pkg::CMD_DUPD) |=> (d0_r <= lim_eff) && (d0_r != '0))
    else $error("Convergent denominator left the allowed range.");
`endif

endmodule

// ===== rtl/brar_ctrl.sv =====
// Controller of the best rational approximation unit: sequences the
// Euclid steps, the semiconvergent and the error comparison.
// Depends on brar_pkg.
module brar_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  brar_pkg::status_t status,
  output brar_pkg::cmd_t    cmd
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_TEST  = 15'b000000000000010,
    S_EDIV  = 15'b000000000000100,
    S_CHK   = 15'b000000000001000,
    S_NUPD  = 15'b000000000010000,
    S_SDIV  = 15'b000000000100000,
    S_SNB   = 15'b000000001000000,
    S_SDB   = 15'b000000010000000,
    S_ERR1  = 15'b000000100000000,
    S_EMUL1 = 15'b000001000000000,
    S_ESAVE = 15'b000010000000000,
    S_ERR2  = 15'b000100000000000,
    S_EMUL2 = 15'b001000000000000,
    S_FCMP  = 15'b010000000000000,
    S_FCONV = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_set;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = brar_pkg::CMD_IDLE;
    out_set   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = brar_pkg::CMD_LOAD;
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (status.q_zero) begin
          state_nxt = S_FCONV;
        end else begin
          cmd       = brar_pkg::CMD_EDIV;
          state_nxt = S_EDIV;
        end
      end
      S_EDIV: begin
        if (status.div_done) begin
          cmd       = brar_pkg::CMD_MCHK;
          state_nxt = S_CHK;
        end else begin
          cmd = brar_pkg::CMD_STEP;
        end
      end
      S_CHK: begin
        if (status.over) begin
          cmd       = brar_pkg::CMD_SDIV;
          state_nxt = S_SDIV;
        end else begin
          cmd       = brar_pkg::CMD_DUPD;
          state_nxt = S_NUPD;
        end
      end
      S_NUPD: begin
        cmd       = brar_pkg::CMD_NUPD;
        state_nxt = S_TEST;
      end
      S_SDIV: begin
        if (status.div_done) begin
          cmd       = brar_pkg::CMD_MCHK;
          state_nxt = S_SNB;
        end else begin
          cmd = brar_pkg::CMD_STEP;
        end
      end
      S_SNB: begin
        cmd       = brar_pkg::CMD_SNB;
        state_nxt = S_SDB;
      end
      S_SDB: begin
        cmd       = brar_pkg::CMD_SDB;
        state_nxt = S_ERR1;
      end
      S_ERR1: begin
        cmd       = brar_pkg::CMD_ERR1;
        state_nxt = S_EMUL1;
      end
      S_EMUL1: begin
        cmd       = brar_pkg::CMD_EMUL1;
        state_nxt = S_ESAVE;
      end
      S_ESAVE: begin
        cmd       = brar_pkg::CMD_ESAVE;
        state_nxt = S_ERR2;
      end
      S_ERR2: begin
        cmd       = brar_pkg::CMD_ERR2;
        state_nxt = S_EMUL2;
      end
      S_EMUL2: begin
        cmd       = brar_pkg::CMD_EMUL2;
        state_nxt = S_FCMP;
      end
      S_FCMP: begin
        if (out_free) begin
          cmd       = brar_pkg::CMD_OCMP;
          out_set   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FCONV: begin
        if (out_free) begin
          cmd       = brar_pkg::CMD_OCONV;
          out_set   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_set || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FCMP) || ($past(state_r) == S_FCONV))
    else $error("A result appeared outside a finishing state.");
`endif

endmodule

// ===== rtl/best_rational_approximation_unit.sv =====
// Sequence: each continued-fraction term after the integer part runs a division and updates;
// then the failing limit check leads to the semiconvergent and the error check, or the unit
// finishes directly when the expansion ends exactly.
// Throughput: one transaction at a time through the bit-serial divider; the next
// transaction is accepted once the controller is back in idle after the result is registered.
// Reset (rst_n, synchronous, active low) clears control and sets the limit to 65535.
module best_rational_approximation_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [brar_pkg::X_W-1:0]      in_x_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [brar_pkg::NUM_W-1:0]    out_numerator,
  output logic [brar_pkg::DEN_W-1:0]    out_denominator,
  input  logic                          cfg_wr_en,
  input  logic [brar_pkg::DEN_W-1:0]    cfg_wr_data
);

  brar_pkg::cmd_t    cmd;
  brar_pkg::status_t status;

  brar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  brar_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .x_value     (in_x_value),
    .cfg_we      (cfg_wr_en),
    .cfg_data    (cfg_wr_data),
    .status      (status),
    .numerator   (out_numerator),
    .denominator (out_denominator)
  );

endmodule
